[rtl/core/ddcn_pkg.sv]
// Shared types, constants and number-format helpers of the detection decode / NMS core.
`timescale 1ns / 1ps

package ddcn_pkg;

    localparam int MAX_DETS    = 64;
    localparam int DET_CW      = $clog2(MAX_DETS + 1);
    localparam int DET_AW      = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [7:0] CFG_NUM_CLASSES = 8'd0;
    localparam logic [7:0] CFG_CONF_THRESH = 8'd1;
    localparam logic [7:0] CFG_IOU_THRESH  = 8'd2;
    localparam logic [7:0] CFG_SCALE_X     = 8'd3;
    localparam logic [7:0] CFG_SCALE_Y     = 8'd4;

    localparam logic [7:0]  RST_NUM_CLASSES = 8'd80;
    localparam logic [12:0] RST_CONF_THRESH = 13'd1024;
    localparam logic [12:0] RST_IOU_THRESH  = 13'd1843;
    localparam logic [15:0] RST_SCALE       = 16'd4096;

    localparam logic [12:0] ONE_Q = 13'd4096;

    typedef struct packed {
        logic [7:0]  num_classes;
        logic [12:0] conf_thresh;
        logic [12:0] iou_thresh;
        logic [15:0] scale_x;
        logic [15:0] scale_y;
    } t_cfg;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [12:0] score;
        logic [7:0]  cls;
    } t_det;

    typedef struct packed {
        logic is_end;
        t_det det;
    } t_qent;

    // fp16 to signed Q12.12, truncated toward zero, saturated
    function automatic logic signed [23:0] half_to_q(input logic [15:0] h);
        logic [4:0]  e;
        logic [27:0] mag;
        logic [23:0] r;
        e   = h[14:10];
        mag = {17'd0, 1'b1, h[9:0]};
        if (e >= 5'd13) begin
            mag = mag << (e - 5'd13);
        end else begin
            mag = mag >> (5'd13 - e);
        end
        if (e == 5'd31) begin
            if (h[9:0] != 10'd0) begin
                r = 24'd0;
            end else begin
                r = h[15] ? 24'h800000 : 24'h7FFFFF;
            end
        end else if (e == 5'd0) begin
            r = 24'd0;
        end else if (h[15]) begin
            r = (mag > 28'h0800000) ? 24'h800000 : (~mag[23:0] + 24'd1);
        end else begin
            r = (mag > 28'h07FFFFF) ? 24'h7FFFFF : mag[23:0];
        end
        return $signed(r);
    endfunction

    function automatic logic [12:0] clamp_unit(input logic signed [23:0] v);
        logic [12:0] r;
        if (v < 0) begin
            r = 13'd0;
        end else if (v > 24'sd4096) begin
            r = ONE_Q;
        end else begin
            r = v[12:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/detection_decode_and_class_nms_core.sv]
// Top level of the detection decode and per-class suppression core.
//
// Input channel (i_in_valid / o_in_ready) takes one fp16 tensor word per
// request, row by row: cx, cy, w, h, objectness, then num_classes scores.
// A word is taken every cycle inside a row; after the last word of a row
// the decoder holds the input while it converts, scale-multiplies and
// saturates, plus any wait for space in the 4-entry candidate queue; the
// frame's last word also pushes an end marker. The back end inserts each
// kept candidate into a score-sorted store of 64 entries with one write and
// one read port, reading and comparing each entry it moves past. After the
// word flagged i_frame_last, suppression walks the store, skipping suppressed
// entries; each survivor is tested against later kept entries of its class.
// Results leave through the output register (o_out_valid / i_out_ready) in
// score order, o_last on the final one; an empty frame gives one none_found
// result. A stalled receiver holds the output register and, through the
// queue, eventually the input channel.
// Configuration (i_cfg_valid, index, data) is always ready; write it only
// while the core is idle. Synchronous reset restores register defaults and
// empties the store; no clearing pass is needed.
`timescale 1ns / 1ps

module detection_decode_and_class_nms_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_word,
    input  logic        i_frame_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [15:0] o_box_x,
    output logic signed [15:0] o_box_y,
    output logic [15:0] o_box_w,
    output logic [15:0] o_box_h,
    output logic [12:0] o_score,
    output logic [7:0]  o_class_id,
    output logic        o_last,
    output logic        o_none_found,
    output logic        o_overflow
);

    ddcn_pkg::t_cfg  r_cfg;
    ddcn_pkg::t_qent push_data;
    ddcn_pkg::t_qent q_data;
    ddcn_pkg::t_det  out_det;
    logic            push;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_classes <= ddcn_pkg::RST_NUM_CLASSES;
            r_cfg.conf_thresh <= ddcn_pkg::RST_CONF_THRESH;
            r_cfg.iou_thresh  <= ddcn_pkg::RST_IOU_THRESH;
            r_cfg.scale_x     <= ddcn_pkg::RST_SCALE;
            r_cfg.scale_y     <= ddcn_pkg::RST_SCALE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ddcn_pkg::CFG_NUM_CLASSES: r_cfg.num_classes <= i_cfg_data[7:0];
                ddcn_pkg::CFG_CONF_THRESH: r_cfg.conf_thresh <= i_cfg_data[12:0];
                ddcn_pkg::CFG_IOU_THRESH:  r_cfg.iou_thresh  <= i_cfg_data[12:0];
                ddcn_pkg::CFG_SCALE_X:     r_cfg.scale_x     <= i_cfg_data;
                ddcn_pkg::CFG_SCALE_Y:     r_cfg.scale_y     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ddcn_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_word       (i_word),
        .i_frame_last (i_frame_last),
        .o_push       (push),
        .o_push_data  (push_data),
        .i_full       (q_full)
    );

    ddcn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    ddcn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_iou_thresh (r_cfg.iou_thresh),
        .i_q_data     (q_data),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_det        (out_det),
        .o_last       (o_last),
        .o_none_found (o_none_found),
        .o_overflow   (o_overflow)
    );

    assign o_box_x    = $signed(out_det.x);
    assign o_box_y    = $signed(out_det.y);
    assign o_box_w    = out_det.w;
    assign o_box_h    = out_det.h;
    assign o_score    = out_det.score;
    assign o_class_id = out_det.cls;

endmodule

[rtl/core/ddcn_fifo.sv]
// Small candidate queue between the row decoder and the store/suppression engine.
`timescale 1ns / 1ps

module ddcn_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ddcn_pkg::t_qent  i_data,
    output logic             o_full,
    input  logic             i_pop,
    output ddcn_pkg::t_qent  o_data,
    output logic             o_empty
);

    ddcn_pkg::t_qent r_mem [ddcn_pkg::QUEUE_DEPTH];
    logic [ddcn_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [ddcn_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [ddcn_pkg::QUEUE_CW-1:0] r_count;
    logic wr_en;
    logic rd_en;

    assign o_full  = (r_count == ddcn_pkg::QUEUE_CW'(ddcn_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/core/ddcn_front.sv]
// Row decoder: fp16 conversion, thresholds, argmax and box scaling into queue entries.
`timescale 1ns / 1ps

module ddcn_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ddcn_pkg::t_cfg   i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [15:0]      i_word,
    input  logic             i_frame_last,
    output logic             o_push,
    output ddcn_pkg::t_qent  o_push_data,
    input  logic             i_full
);

    typedef enum logic [4:0] {
        S_RUN = 5'b00001,
        S_F1  = 5'b00010,
        S_F2  = 5'b00100,
        S_F3  = 5'b01000,
        S_END = 5'b10000
    } t_fstate;

    t_fstate r_state;
    t_fstate n_state;

    logic [8:0]  r_pos;
    logic [15:0] r_cx, r_cy, r_w, r_h;
    logic [12:0] r_obj;
    logic        r_alive;
    logic [12:0] r_best;
    logic [7:0]  r_bidx;
    logic        r_fl_pend;

    logic signed [25:0] r_dx, r_dy;
    logic [22:0]        r_wp, r_hp;
    logic [25:0]        r_prod;
    logic signed [42:0] r_px, r_py;
    logic [38:0]        r_pw, r_ph;
    logic [12:0]        r_sc;

    logic               accept;
    logic               finish;
    logic signed [23:0] q_in;
    logic [12:0]        u_in;
    logic signed [23:0] cxq, cyq, wq, hq;
    logic signed [21:0] bx_s, by_s;
    logic [18:0]        bw_s, bh_s;
    logic               cand_keep;
    ddcn_pkg::t_det     cand;

    assign o_ready = (r_state == S_RUN);
    assign accept  = i_valid && o_ready;
    assign q_in    = ddcn_pkg::half_to_q(i_word);
    assign u_in    = ddcn_pkg::clamp_unit(q_in);
    assign finish  = ({1'b0, r_pos} >= (10'd4 + {2'd0, i_cfg.num_classes}));

    assign cxq = ddcn_pkg::half_to_q(r_cx);
    assign cyq = ddcn_pkg::half_to_q(r_cy);
    assign wq  = ddcn_pkg::half_to_q(r_w);
    assign hq  = ddcn_pkg::half_to_q(r_h);

    // floor by arithmetic shift, then saturate to the output formats
    assign bx_s = r_px[42:21];
    assign by_s = r_py[42:21];
    assign bw_s = r_pw[38:20];
    assign bh_s = r_ph[38:20];

    always_comb begin
        cand.score = r_sc;
        cand.cls   = r_bidx;
        if (bx_s > 22'sd32767) begin
            cand.x = 16'h7FFF;
        end else if (bx_s < -22'sd32768) begin
            cand.x = 16'h8000;
        end else begin
            cand.x = bx_s[15:0];
        end
        if (by_s > 22'sd32767) begin
            cand.y = 16'h7FFF;
        end else if (by_s < -22'sd32768) begin
            cand.y = 16'h8000;
        end else begin
            cand.y = by_s[15:0];
        end
        cand.w = (bw_s > 19'd65535) ? 16'hFFFF : bw_s[15:0];
        cand.h = (bh_s > 19'd65535) ? 16'hFFFF : bh_s[15:0];
    end

    assign cand_keep = r_alive && (r_sc >= i_cfg.conf_thresh);

    always_comb begin
        o_push             = 1'b0;
        o_push_data.is_end = 1'b0;
        o_push_data.det    = cand;
        n_state            = r_state;
        unique case (r_state)
            S_RUN: begin
                if (accept) begin
                    if (finish) begin
                        n_state = S_F1;
                    end else if (i_frame_last) begin
                        n_state = S_END;
                    end
                end
            end
            S_F1: n_state = S_F2;
            S_F2: n_state = S_F3;
            S_F3: begin
                o_push = cand_keep;
                if (!cand_keep || !i_full) begin
                    n_state = r_fl_pend ? S_END : S_RUN;
                end
            end
            S_END: begin
                o_push             = 1'b1;
                o_push_data.is_end = 1'b1;
                o_push_data.det    = '0;
                if (!i_full) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_pos     <= '0;
            r_fl_pend <= 1'b0;
            r_alive   <= 1'b0;
            r_obj     <= '0;
            r_best    <= '0;
            r_bidx    <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if (r_pos < 9'd4) begin
                    unique case (r_pos[1:0])
                        2'd0: r_cx <= i_word;
                        2'd1: r_cy <= i_word;
                        2'd2: r_w  <= i_word;
                        2'd3: r_h  <= i_word;
                        default: r_cx <= i_word;
                    endcase
                end else if (r_pos == 9'd4) begin
                    r_alive <= (q_in >= $signed({11'd0, i_cfg.conf_thresh}));
                    r_obj   <= ddcn_pkg::clamp_unit(q_in);
                    r_best  <= '0;
                    r_bidx  <= '0;
                end else if (u_in > r_best) begin
                    r_best <= u_in;
                    r_bidx <= 8'(r_pos - 9'd5);
                end
                r_fl_pend <= i_frame_last;
                if (finish || i_frame_last) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_F1) begin
            r_dx   <= $signed({cxq[23], cxq, 1'b0}) - $signed({{2{wq[23]}}, wq});
            r_dy   <= $signed({cyq[23], cyq, 1'b0}) - $signed({{2{hq[23]}}, hq});
            r_wp   <= wq[23] ? 23'd0 : wq[22:0];
            r_hp   <= hq[23] ? 23'd0 : hq[22:0];
            r_prod <= r_obj * r_best;
        end
        if (r_state == S_F2) begin
            r_px <= r_dx * $signed({1'b0, i_cfg.scale_x});
            r_py <= r_dy * $signed({1'b0, i_cfg.scale_y});
            r_pw <= r_wp * i_cfg.scale_x;
            r_ph <= r_hp * i_cfg.scale_y;
            r_sc <= r_prod[24:12];
        end
    end

endmodule

[rtl/core/ddcn_back.sv]
// Score-sorted detection store, same-class suppression and result register.
`timescale 1ns / 1ps

module ddcn_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [12:0]      i_iou_thresh,
    input  ddcn_pkg::t_qent  i_q_data,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output ddcn_pkg::t_det   o_det,
    output logic             o_last,
    output logic             o_none_found,
    output logic             o_overflow
);

    localparam int CW = ddcn_pkg::DET_CW;
    localparam int AW = ddcn_pkg::DET_AW;
    localparam logic [CW-1:0] FULL_CNT = CW'(ddcn_pkg::MAX_DETS);

    typedef enum logic [10:0] {
        B_IDLE    = 11'b00000000001,
        B_INS_RD  = 11'b00000000010,
        B_INS_CMP = 11'b00000000100,
        B_SCAN    = 11'b00000001000,
        B_LOAD    = 11'b00000010000,
        B_JSCAN   = 11'b00000100000,
        B_J1      = 11'b00001000000,
        B_J2      = 11'b00010000000,
        B_J3      = 11'b00100000000,
        B_J4      = 11'b01000000000,
        B_FINAL   = 11'b10000000000
    } t_bstate;

    t_bstate r_state, n_state;

    ddcn_pkg::t_det r_mem [ddcn_pkg::MAX_DETS];
    ddcn_pkg::t_det r_rdata;

    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_i, n_i;
    logic [CW-1:0]                r_j, n_j;
    logic                         r_ovf, n_ovf;
    logic                         r_full, n_full;
    logic                         r_have, n_have;
    logic [ddcn_pkg::MAX_DETS-1:0] r_keep, n_keep;
    ddcn_pkg::t_det               r_new;
    ddcn_pkg::t_det               r_a;
    logic [31:0]                  r_a_area;
    logic [15:0]                  r_iw, r_ih, r_bw, r_bh;
    logic [31:0]                  r_inter, r_b_area;
    logic [43:0]                  r_lhs;
    logic [45:0]                  r_rhs;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    ddcn_pkg::t_det mem_wdata;
    logic [AW-1:0]  mem_raddr;

    logic           out_free;
    logic           out_load;
    ddcn_pkg::t_det out_det;
    logic           out_last;
    logic           out_none;
    logic           r_out_valid;

    logic signed [17:0] ax1, ax2, bx1, bx2, ay1, ay2, by1, by2;
    logic signed [17:0] lo_x, hi_x, lo_y, hi_y, dw, dh;
    logic [32:0]        uni;

    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;

    // intersection extents from the held box and the box just read
    always_comb begin
        ax1  = 18'($signed(r_a.x));
        ay1  = 18'($signed(r_a.y));
        ax2  = ax1 + $signed({2'b00, r_a.w});
        ay2  = ay1 + $signed({2'b00, r_a.h});
        bx1  = 18'($signed(r_rdata.x));
        by1  = 18'($signed(r_rdata.y));
        bx2  = bx1 + $signed({2'b00, r_rdata.w});
        by2  = by1 + $signed({2'b00, r_rdata.h});
        lo_x = (ax1 > bx1) ? ax1 : bx1;
        hi_x = (ax2 < bx2) ? ax2 : bx2;
        lo_y = (ay1 > by1) ? ay1 : by1;
        hi_y = (ay2 < by2) ? ay2 : by2;
        dw   = hi_x - lo_x;
        dh   = hi_y - lo_y;
        uni  = {1'b0, r_a_area} + {1'b0, r_b_area} - {1'b0, r_inter};
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_i       = r_i;
        n_j       = r_j;
        n_ovf     = r_ovf;
        n_full    = r_full;
        n_have    = r_have;
        n_keep    = r_keep;
        o_q_pop   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_i[AW-1:0];
        mem_wdata = r_new;
        mem_raddr = r_i[AW-1:0];
        out_load  = 1'b0;
        out_det   = r_a;
        out_last  = 1'b0;
        out_none  = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (i_q_data.is_end) begin
                        n_i     = '0;
                        n_state = B_SCAN;
                    end else begin
                        n_full  = (r_count == FULL_CNT);
                        n_i     = r_count;
                        if (r_count == FULL_CNT) begin
                            n_ovf = 1'b1;
                        end
                        n_state = B_INS_RD;
                    end
                end
            end
            B_INS_RD: begin
                if (r_i == '0) begin
                    mem_we  = 1'b1;
                    n_count = r_full ? r_count : r_count + 1'b1;
                    n_state = B_IDLE;
                end else begin
                    mem_raddr = AW'(r_i - 1'b1);
                    n_state   = B_INS_CMP;
                end
            end
            B_INS_CMP: begin
                // a full store has no slot past its end: the bottom entry falls off
                if (r_rdata.score < r_new.score) begin
                    mem_we    = (r_i != FULL_CNT);
                    mem_wdata = r_rdata;
                    n_i       = r_i - 1'b1;
                    n_state   = B_INS_RD;
                end else begin
                    mem_we  = (r_i != FULL_CNT);
                    if (r_i != FULL_CNT) begin
                        n_count = r_full ? r_count : r_count + 1'b1;
                    end
                    n_state = B_IDLE;
                end
            end
            B_SCAN: begin
                if (r_i == r_count) begin
                    n_state = B_FINAL;
                end else if (!r_keep[r_i[AW-1:0]]) begin
                    n_i = r_i + 1'b1;
                end else if (!r_have || out_free) begin
                    // the previous survivor is known not to be the last one now
                    out_load = r_have;
                    n_state  = B_LOAD;
                end
            end
            B_LOAD: begin
                n_have  = 1'b1;
                n_j     = r_i + 1'b1;
                n_state = B_JSCAN;
            end
            B_JSCAN: begin
                mem_raddr = r_j[AW-1:0];
                if (r_j == r_count) begin
                    n_i     = r_i + 1'b1;
                    n_state = B_SCAN;
                end else if (!r_keep[r_j[AW-1:0]]) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_state = B_J1;
                end
            end
            B_J1: begin
                if (r_rdata.cls != r_a.cls) begin
                    n_j     = r_j + 1'b1;
                    n_state = B_JSCAN;
                end else begin
                    n_state = B_J2;
                end
            end
            B_J2: n_state = B_J3;
            B_J3: n_state = B_J4;
            B_J4: begin
                if ({2'b00, r_lhs} > r_rhs) begin
                    n_keep[r_j[AW-1:0]] = 1'b0;
                end
                n_j     = r_j + 1'b1;
                n_state = B_JSCAN;
            end
            B_FINAL: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    out_none = !r_have;
                    out_det  = r_have ? r_a : '0;
                    n_count  = '0;
                    n_ovf    = 1'b0;
                    n_have   = 1'b0;
                    n_keep   = '1;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE) begin
            r_new <= i_q_data.det;
        end
        if (r_state == B_LOAD) begin
            r_a      <= r_rdata;
            r_a_area <= r_rdata.w * r_rdata.h;
        end
        if (r_state == B_J1) begin
            r_iw <= dw[17] ? 16'd0 : dw[15:0];
            r_ih <= dh[17] ? 16'd0 : dh[15:0];
            r_bw <= r_rdata.w;
            r_bh <= r_rdata.h;
        end
        if (r_state == B_J2) begin
            r_inter  <= r_iw * r_ih;
            r_b_area <= r_bw * r_bh;
        end
        if (r_state == B_J3) begin
            r_lhs <= {r_inter, 12'd0};
            r_rhs <= i_iou_thresh * uni;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_count     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_ovf       <= 1'b0;
            r_full      <= 1'b0;
            r_have      <= 1'b0;
            r_keep      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_i     <= n_i;
            r_j     <= n_j;
            r_ovf   <= n_ovf;
            r_full  <= n_full;
            r_have  <= n_have;
            r_keep  <= n_keep;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_det        <= out_det;
            o_last       <= out_last;
            o_none_found <= out_none;
            o_overflow   <= r_ovf;
        end
    end

endmodule

[rtl/core/ddcn_checker.sv]
// Port-level checks of the detection decode / NMS core, bound to the top level.
`timescale 1ns / 1ps

module ddcn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic signed [15:0] o_box_x,
    input logic signed [15:0] o_box_y,
    input logic [15:0] o_box_w,
    input logic [15:0] o_box_h,
    input logic [12:0] o_score,
    input logic [7:0]  o_class_id,
    input logic        o_last,
    input logic        o_none_found,
    input logic        o_overflow
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable({o_box_x, o_box_y, o_box_w, o_box_h,
            o_score, o_class_id, o_last, o_none_found, o_overflow}))
        else $error("result changed while stalled");

    a_none_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_none_found |-> o_last && o_box_x == 16'sd0 &&
            o_box_y == 16'sd0 && o_box_w == 16'd0 && o_box_h == 16'd0 &&
            o_score == 13'd0 && o_class_id == 8'd0)
        else $error("empty-frame result malformed");

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_score <= 13'd4096)
        else $error("score above one");

endmodule

bind detection_decode_and_class_nms_core ddcn_checker u_ddcn_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the detection decode and per-class suppression core.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [12:0] score;
        logic [7:0]  cls;
        logic        last;
        logic        none;
        logic        ovf;
    } t_result;

    typedef struct packed {
        logic [15:0] word;
        logic        flast;
        logic        empty_known;
    } t_row;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [15:0] i_word = '0;
    logic        i_frame_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic signed [15:0] o_box_x;
    logic signed [15:0] o_box_y;
    logic [15:0] o_box_w;
    logic [15:0] o_box_h;
    logic [12:0] o_score;
    logic [7:0]  o_class_id;
    logic        o_last;
    logic        o_none_found;
    logic        o_overflow;

    detection_decode_and_class_nms_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // predictor state
    int        p_nc, p_conf, p_iou, p_sx, p_sy;
    int        wpos, row_obj, best_sc, best_idx;
    bit        row_ok;
    logic [15:0] row_word [4];
    int        s_x [ddcn_pkg::MAX_DETS], s_y [ddcn_pkg::MAX_DETS];
    int        s_w [ddcn_pkg::MAX_DETS], s_h [ddcn_pkg::MAX_DETS];
    int        s_sc [ddcn_pkg::MAX_DETS], s_cls [ddcn_pkg::MAX_DETS];
    bit        s_keep [ddcn_pkg::MAX_DETS];
    int        s_cnt;
    bit        s_ovf;

    t_result   pending_dets [$];
    int        errors = 0;
    int        idle_in = 0;
    int        stall_out = 0;

    function automatic int half_to_fix(logic [15:0] h);
        int     e;
        longint mag;
        e = h[14:10];
        if (e == 31) begin
            if (h[9:0] != 0) return 0;
            return h[15] ? -8388608 : 8388607;
        end
        if (e == 0) return 0;
        mag = {1'b1, h[9:0]};
        if (e >= 13) mag = mag << (e - 13);
        else mag = mag >> (13 - e);
        if (h[15]) return (mag > 8388608) ? -8388608 : -int'(mag);
        return (mag > 8388607) ? 8388607 : int'(mag);
    endfunction

    function automatic int to_unit(int v);
        if (v < 0) return 0;
        if (v > 4096) return 4096;
        return v;
    endfunction

    function automatic int sat_signed16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic int sat_unsigned16(longint v);
        if (v < 0) return 0;
        if (v > 65535) return 65535;
        return int'(v);
    endfunction

    function automatic void clear_frame_state();
        wpos = 0; row_obj = 0; row_ok = 0; best_sc = 0; best_idx = 0;
        s_cnt = 0; s_ovf = 0;
        foreach (s_keep[i]) s_keep[i] = 1'b1;
        foreach (row_word[i]) row_word[i] = '0;
    endfunction

    function automatic void expect_result(t_result r);
        pending_dets = {pending_dets, r};
    endfunction

    function automatic void insert_candidate(int x, int y, int w, int h, int sc, int cls);
        int slot, n;
        slot = 0;
        n = s_cnt;
        while (slot < n && s_sc[slot] >= sc) slot++;
        if (n >= ddcn_pkg::MAX_DETS) begin
            s_ovf = 1'b1;
            if (slot >= ddcn_pkg::MAX_DETS) return;
            n = ddcn_pkg::MAX_DETS - 1;
        end
        for (int i = n; i > slot; i--) begin
            s_x[i] = s_x[i-1]; s_y[i] = s_y[i-1]; s_w[i] = s_w[i-1];
            s_h[i] = s_h[i-1]; s_sc[i] = s_sc[i-1]; s_cls[i] = s_cls[i-1];
        end
        s_x[slot] = x; s_y[slot] = y; s_w[slot] = w; s_h[slot] = h;
        s_sc[slot] = sc; s_cls[slot] = cls;
        s_cnt = n + 1;
    endfunction

    function automatic void close_row();
        longint cx, cy, w, h;
        int     sc;
        cx = half_to_fix(row_word[0]);
        cy = half_to_fix(row_word[1]);
        w  = half_to_fix(row_word[2]);
        h  = half_to_fix(row_word[3]);
        sc = (row_obj * best_sc) >>> 12;
        if (!row_ok || sc < p_conf) return;
        insert_candidate(sat_signed16(((2 * cx - w) * longint'(p_sx)) >>> 21),
                         sat_signed16(((2 * cy - h) * longint'(p_sy)) >>> 21),
                         sat_unsigned16(((w < 0) ? 0 : w) * longint'(p_sx) >>> 20),
                         sat_unsigned16(((h < 0) ? 0 : h) * longint'(p_sy) >>> 20),
                         sc, best_idx);
    endfunction

    function automatic bit iou_above(int a, int b);
        longint ax2, ay2, bx2, by2, iw, ih, inter, uni;
        ax2 = longint'(s_x[a]) + s_w[a]; ay2 = longint'(s_y[a]) + s_h[a];
        bx2 = longint'(s_x[b]) + s_w[b]; by2 = longint'(s_y[b]) + s_h[b];
        iw = ((ax2 < bx2) ? ax2 : bx2) - ((s_x[a] > s_x[b]) ? s_x[a] : s_x[b]);
        ih = ((ay2 < by2) ? ay2 : by2) - ((s_y[a] > s_y[b]) ? s_y[a] : s_y[b]);
        if (iw < 0) iw = 0;
        if (ih < 0) ih = 0;
        inter = iw * ih;
        uni = longint'(s_w[a]) * s_h[a] + longint'(s_w[b]) * s_h[b] - inter;
        return inter * 4096 > longint'(p_iou) * uni;
    endfunction

    // one accepted tensor word; if queue_dets, queues this frame's results at frame end
    function automatic void decode_word(logic [15:0] wd, logic fl, bit queue_dets);
        int      v, o, n;
        t_result r;
        if (wpos < 4) begin
            row_word[wpos] = wd;
        end else if (wpos == 4) begin
            o = half_to_fix(wd);
            row_ok = (o >= p_conf);
            row_obj = to_unit(o);
            best_sc = 0;
            best_idx = 0;
        end else begin
            v = to_unit(half_to_fix(wd));
            if (v > best_sc) begin
                best_sc = v;
                best_idx = (wpos - 5) & 255;
            end
        end
        if (wpos >= 4 + p_nc) begin
            close_row();
            wpos = 0;
        end else begin
            wpos = (wpos + 1) & 511;
        end
        if (!fl) return;
        n = 0;
        for (int i = 0; i < s_cnt; i++) begin
            if (!s_keep[i]) continue;
            r = '0;
            r.x = 16'(s_x[i]); r.y = 16'(s_y[i]); r.w = 16'(s_w[i]); r.h = 16'(s_h[i]);
            r.score = 13'(s_sc[i]); r.cls = 8'(s_cls[i]); r.ovf = s_ovf;
            if (queue_dets) expect_result(r);
            n++;
            for (int j = i + 1; j < s_cnt; j++)
                if (s_keep[j] && s_cls[j] == s_cls[i] && iou_above(i, j))
                    s_keep[j] = 1'b0;
        end
        if (n == 0 && queue_dets) begin
            r = '0;
            r.none = 1'b1;
            r.ovf = s_ovf;
            expect_result(r);
        end
        if (queue_dets) pending_dets[$].last = 1'b1;
        clear_frame_state();
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_dets.size() == 0) begin
                report_mismatch("result count", 1, 0);
            end else begin
                want = pending_dets.pop_front();
                if (o_box_x !== want.x) report_mismatch("box_x", o_box_x, $signed(want.x));
                if (o_box_y !== want.y) report_mismatch("box_y", o_box_y, $signed(want.y));
                if (o_box_w !== want.w) report_mismatch("box_w", o_box_w, want.w);
                if (o_box_h !== want.h) report_mismatch("box_h", o_box_h, want.h);
                if (o_score !== want.score) report_mismatch("score", o_score, want.score);
                if (o_class_id !== want.cls) report_mismatch("class_id", o_class_id, want.cls);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
                if (o_none_found !== want.none)
                    report_mismatch("none_found", o_none_found, want.none);
                if (o_overflow !== want.ovf) report_mismatch("overflow", o_overflow, want.ovf);
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_out);
    end

    task automatic send_word(logic [15:0] wd, logic fl, bit queue_dets);
        while ($urandom_range(99) < idle_in) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_word <= wd;
        i_frame_last <= fl;
        do @(posedge i_clk); while (!o_in_ready);
        decode_word(wd, fl, queue_dets);
    endtask

    task automatic write_reg(logic [7:0] idx, int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ddcn_pkg::CFG_NUM_CLASSES: p_nc = val & 8'hFF;
            ddcn_pkg::CFG_CONF_THRESH: p_conf = val & 13'h1FFF;
            ddcn_pkg::CFG_IOU_THRESH:  p_iou = val & 13'h1FFF;
            ddcn_pkg::CFG_SCALE_X:     p_sx = val & 16'hFFFF;
            ddcn_pkg::CFG_SCALE_Y:     p_sy = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_dets.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic apply_config(int nc, int conf, int iou, int sx, int sy);
        write_reg(ddcn_pkg::CFG_NUM_CLASSES, nc);
        write_reg(ddcn_pkg::CFG_CONF_THRESH, conf);
        write_reg(ddcn_pkg::CFG_IOU_THRESH, iou);
        write_reg(ddcn_pkg::CFG_SCALE_X, sx);
        write_reg(ddcn_pkg::CFG_SCALE_Y, sy);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_half(int elo, int ehi, int neg_pct);
        return {1'($urandom_range(99) < neg_pct), 5'($urandom_range(ehi, elo)),
                10'($urandom)};
    endfunction

    // one frame of rows; dense rows keep every candidate
    task automatic send_frame(int rows, bit dense);
        logic [15:0] wd;
        int          total, k, tail;
        tail = ($urandom_range(9) == 0 || rows == 0) ? $urandom_range(3, 1) : 0;
        total = rows * (5 + p_nc) + tail;
        k = 0;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < 5 + p_nc; c++) begin
                case (c)
                    0, 1: wd = rand_half(20, 22, 3);
                    2, 3: wd = rand_half(17, 21, 5);
                    4:    wd = dense ? 16'h3C00 : rand_half(11, 15, 5);
                    default: wd = dense ? rand_half(13, 14, 0) : rand_half(9, 14, 5);
                endcase
                if (!dense && $urandom_range(99) < 6) wd = 16'($urandom);
                k++;
                send_word(wd, k == total, 1'b1);
            end
        end
        for (int t = 0; t < tail; t++) begin
            k++;
            send_word(16'($urandom), k == total, 1'b1);
        end
    endtask

    // directed rows with two classes per row
    localparam int N_DIR = 25;
    localparam t_row DIRECTED [N_DIR] = '{
        '{16'h5640, 1'b1, 1'b1},      // lone word ends frame: partial row dropped
        '{16'h7C00, 1'b0, 1'b0}, '{16'hFC00, 1'b0, 1'b0}, '{16'hFC00, 1'b0, 1'b0},
        '{16'h7BFF, 1'b0, 1'b0}, '{16'h3C00, 1'b0, 1'b0}, '{16'h3C00, 1'b0, 1'b0},
        '{16'h3C00, 1'b1, 1'b0},      // infinities, negative width, tied classes
        '{16'h0001, 1'b0, 1'b0}, '{16'h7E00, 1'b0, 1'b0}, '{16'h0000, 1'b0, 1'b0},
        '{16'h8000, 1'b0, 1'b0}, '{16'h3400, 1'b0, 1'b0}, '{16'h0000, 1'b0, 1'b0},
        '{16'h7BFF, 1'b1, 1'b0},      // subnormal, NaN, objectness at threshold
        '{16'h5000, 1'b0, 1'b0}, '{16'h5000, 1'b0, 1'b0}, '{16'h4800, 1'b0, 1'b0},
        '{16'h4800, 1'b0, 1'b0}, '{16'h33FF, 1'b0, 1'b0}, '{16'h3C00, 1'b0, 1'b0},
        '{16'h3C00, 1'b1, 1'b1},      // objectness just under threshold
        '{16'hFFFF, 1'b0, 1'b0}, '{16'h8001, 1'b0, 1'b0}, '{16'hFFFF, 1'b1, 1'b1}
    };

    initial begin
        t_result lit;
        int      nrows, words;
        p_nc = ddcn_pkg::RST_NUM_CLASSES; p_conf = ddcn_pkg::RST_CONF_THRESH;
        p_iou = ddcn_pkg::RST_IOU_THRESH;
        p_sx = ddcn_pkg::RST_SCALE; p_sy = ddcn_pkg::RST_SCALE;
        clear_frame_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_config(2, 1024, 1843, 4096, 4096);
        foreach (DIRECTED[i]) begin
            send_word(DIRECTED[i].word, DIRECTED[i].flast, !DIRECTED[i].empty_known);
            if (DIRECTED[i].empty_known) begin
                lit = '0;
                lit.none = 1'b1;
                lit.last = 1'b1;
                expect_result(lit);
            end
        end
        wait_idle();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: apply_config(2, 1024, 1843, 4096, 4096);
                1: apply_config(3, 0, 0, 65535, 0);
                2: apply_config(1, 4096, 4096, 0, 65535);
                3: apply_config(0, 0, 2000, 8192, 3000);
                4: apply_config(255, 1024, 1843, 4096, 4096);
                5: apply_config(2, 600, 1000, 5000, 4500);
                6: apply_config(4, 300, 2500, 3000, 6000);
                7: apply_config(1, 800, 1843, 4096, 4096);
                default: apply_config(2, 400, 1500, 4096, 4096);
            endcase
            idle_in = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 66 : 38) : 0;
            stall_out = (ph % 4 == 2) ? 66 : ((ph % 4 == 3) ? 38 : 0);
            if (ph == 3) begin
                send_frame(ddcn_pkg::MAX_DETS + 2, 1'b1);   // fills the store past capacity
            end else if (ph == 4) begin
                send_frame(0, 1'b0);
            end else begin
                words = 0;
                while (words < 8) begin
                    nrows = $urandom_range(2, 0);
                    send_frame(nrows, 1'b0);
                    words += nrows * (5 + p_nc) + 1;
                    if (ph == 0) wait_idle();
                end
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[detection_decode_and_class_nms_core.f]
rtl/core/ddcn_pkg.sv
rtl/core/ddcn_fifo.sv
rtl/core/ddcn_front.sv
rtl/core/ddcn_back.sv
rtl/core/detection_decode_and_class_nms_core.sv
rtl/core/ddcn_checker.sv
tb/testbench.sv
